>>> hdl/epcd_pkg.sv
package epcd_pkg;

  // motor pulse length in ticks for each polarity
  localparam int unsigned PULSE_TICKS = 3;
  localparam int unsigned PHASE_LAST  = 2 * PULSE_TICKS + 1;
  localparam int unsigned PHASE_W     = $clog2(PHASE_LAST + 1);

  localparam int unsigned POWER_W = 20;
  localparam int unsigned WDOG_W  = 24;
  localparam int unsigned ACC_W   = 32;

  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  localparam logic [ACC_W-1:0]  ROLL_LIMIT_RST      = 32'd100000;
  localparam logic [WDOG_W-1:0] WATCHDOG_RELOAD_RST = 24'd3000;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_POWER = 1'b1
  } op_e;

  // register word index, taken from paddr[2]
  typedef enum logic {
    REG_ROLL_LIMIT      = 1'b0,
    REG_WATCHDOG_RELOAD = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic               opcode;
    logic [POWER_W-1:0] power_watts;
  } in_item_t;

  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic tick_due;
    logic running;
  } out_item_t;

  typedef struct packed {
    logic [ACC_W-1:0]  roll_limit;
    logic [WDOG_W-1:0] watchdog_reload;
  } cfg_t;

endpackage

>>> hdl/epcd_regs.sv
module epcd_regs import epcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.roll_limit      <= ROLL_LIMIT_RST;
      cfg_q.watchdog_reload <= WATCHDOG_RELOAD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_ROLL_LIMIT:      cfg_q.roll_limit      <= pwdata[ACC_W-1:0];
        REG_WATCHDOG_RELOAD: cfg_q.watchdog_reload <= pwdata[WDOG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ROLL_LIMIT:      prdata = APB_DW'(cfg_q.roll_limit);
      REG_WATCHDOG_RELOAD: prdata = APB_DW'(cfg_q.watchdog_reload);
      default:             prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/epcd_step.sv
module epcd_step import epcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      accept_i,
  input  in_item_t  item_i,
  output out_item_t result_o
);

  localparam logic [PHASE_W-1:0] PH_WAIT_PLUS  = '0;
  localparam logic [PHASE_W-1:0] PH_WAIT_MINUS = PHASE_W'(PULSE_TICKS + 1);
  localparam logic [PHASE_W-1:0] PH_LAST       = PHASE_W'(PHASE_LAST);

  logic [POWER_W-1:0] power_q, power_d;
  logic [WDOG_W-1:0]  wdog_q, wdog_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [1:0]         pins_q, pins_d;   // bit 0 pin a, bit 1 pin b

  logic [ACC_W-1:0] sum;
  logic             due;
  logic             tick_live;

  // sum and rollover compare; subtract runs in parallel with the compare
  assign sum       = acc_q + ACC_W'(power_q);
  assign due       = sum > cfg_i.roll_limit;
  assign tick_live = (op_e'(item_i.opcode) == OP_TICK) && (wdog_q != '0);

  always_comb begin
    power_d = power_q;
    wdog_d  = wdog_q;
    acc_d   = acc_q;
    phase_d = phase_q;
    pins_d  = pins_q;
    if (op_e'(item_i.opcode) == OP_POWER) begin
      power_d = item_i.power_watts;
      wdog_d  = cfg_i.watchdog_reload;
    end else if (tick_live) begin
      wdog_d = wdog_q - WDOG_W'(1);
      acc_d  = due ? (sum - cfg_i.roll_limit) : sum;
      // pins follow the phase current at the tick, then the phase advances
      if (phase_q == PH_WAIT_PLUS) begin
        pins_d = 2'b00;
        if (due) begin
          phase_d = PHASE_W'(1);
        end
      end else if (phase_q < PH_WAIT_MINUS) begin
        pins_d  = 2'b01;
        phase_d = phase_q + PHASE_W'(1);
      end else if (phase_q == PH_WAIT_MINUS) begin
        pins_d = 2'b11;
        if (due) begin
          phase_d = phase_q + PHASE_W'(1);
        end
      end else begin
        pins_d  = 2'b10;
        phase_d = (phase_q >= PH_LAST) ? PH_WAIT_PLUS : phase_q + PHASE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= '0;
      wdog_q  <= '0;
      acc_q   <= '0;
      phase_q <= '0;
      pins_q  <= '0;
    end else if (accept_i) begin
      power_q <= power_d;
      wdog_q  <= wdog_d;
      acc_q   <= acc_d;
      phase_q <= phase_d;
      pins_q  <= pins_d;
    end
  end

  assign result_o.pin_a    = pins_d[0];
  assign result_o.pin_b    = pins_d[1];
  assign result_o.tick_due = tick_live && due;
  assign result_o.running  = (wdog_d != '0);

endmodule

>>> hdl/energy_proportional_clock_drive.sv
// Energy-proportional clock drive: each item is a timer tick (opcode 0) or a new
// power reading (opcode 1). A reading reloads the watchdog; each tick while the
// watchdog runs adds the stored power to a 32-bit accumulator, and a sum above
// the rollover limit steps the motor sequencer (wait, pin a pulse, wait, pin b pulse).
// One item is accepted every cycle while in_ready_o is high; its result is registered
// into the output register. A second slot lets the block take one more item while
// a result waits, so in_ready_o drops only when both slots hold results.
// The per-item path is one 32-bit add followed by compare and subtract.
// Registers: 0x0 rollover limit (reset 100000), 0x4 watchdog_reload (reset 3000,
// 24 bits). Write them only while no item is in flight.
module energy_proportional_clock_drive import epcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  out_item_t result;
  logic      push, pop;

  out_item_t out_q, skid_q;
  logic      out_valid_q, skid_valid_q;

  epcd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  epcd_step u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .accept_i (push),
    .item_i   (in_data_i),
    .result_o (result)
  );

  // ready only from registered state: the skid slot is free
  assign in_ready_o = !skid_valid_q;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = out_valid_q && out_ready_i;

  // two-slot output buffer: out_q is the head, skid_q holds the next item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= push;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // payload slots, no reset needed
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push) begin
        out_q <= result;
      end
    end else if (push) begin
      if (!out_valid_q) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sim/clock_drive_checker.sv
`timescale 1ns / 1ps

module clock_drive_checker import epcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_item_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_item_t         out_data_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int                fail_count_o,
  output int                pending_count_o,
  output int                steps_due_o
);

  localparam int unsigned WAIT_PLUS  = 0;
  localparam int unsigned WAIT_MINUS = PULSE_TICKS + 1;

  localparam logic [1:0] PINS_LOW  = 2'b00;
  localparam logic [1:0] PINS_A    = 2'b01;
  localparam logic [1:0] PINS_B    = 2'b10;
  localparam logic [1:0] PINS_BOTH = 2'b11;

  cfg_t                drive_cfg;
  logic [POWER_W-1:0]  power_level;
  logic [WDOG_W-1:0]   watchdog_count;
  logic [ACC_W-1:0]    energy_acc;
  logic [PHASE_W-1:0]  phase;
  logic [1:0]          pin_levels;

  out_item_t           predicted_outputs[$];
  int                  mismatches;
  int                  steps_due;

  // one item through the drive model, state advanced in place
  function automatic out_item_t predict_drive(in_item_t item);
    out_item_t res;
    logic      due;
    due = 1'b0;
    if (item.opcode == OP_POWER) begin
      power_level    = item.power_watts;
      watchdog_count = drive_cfg.watchdog_reload;
    end else if (watchdog_count != '0) begin
      watchdog_count = watchdog_count - 1'b1;
      energy_acc     = energy_acc + ACC_W'(power_level);
      if (energy_acc > drive_cfg.roll_limit) begin
        energy_acc = energy_acc - drive_cfg.roll_limit;
        due        = 1'b1;
      end
      // pins come from the phase current at the tick
      if (phase == WAIT_PLUS) begin
        pin_levels = PINS_LOW;
        if (due) phase = PHASE_W'(WAIT_PLUS + 1);
      end else if (phase < WAIT_MINUS) begin
        pin_levels = PINS_A;
        phase      = phase + 1'b1;
      end else if (phase == WAIT_MINUS) begin
        pin_levels = PINS_BOTH;
        if (due) phase = PHASE_W'(WAIT_MINUS + 1);
      end else begin
        pin_levels = PINS_B;
        phase      = (phase >= PHASE_LAST) ? PHASE_W'(WAIT_PLUS) : phase + 1'b1;
      end
    end
    res.pin_a    = pin_levels[0];
    res.pin_b    = pin_levels[1];
    res.tick_due = due;
    res.running  = (watchdog_count != '0);
    return res;
  endfunction

  task automatic check_field(input string field, input logic want, input logic got);
    if (want !== got) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    out_item_t want;
    if (!rst_ni) begin
      drive_cfg.roll_limit      = ROLL_LIMIT_RST;
      drive_cfg.watchdog_reload = WATCHDOG_RELOAD_RST;
      power_level     = '0;
      watchdog_count  = '0;
      energy_acc      = '0;
      phase           = '0;
      pin_levels      = PINS_LOW;
      mismatches      = 0;
      steps_due       = 0;
      predicted_outputs.delete();
      fail_count_o    <= 0;
      pending_count_o <= 0;
      steps_due_o     <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[2]))
          REG_ROLL_LIMIT:      drive_cfg.roll_limit      = pwdata[ACC_W-1:0];
          REG_WATCHDOG_RELOAD: drive_cfg.watchdog_reload = pwdata[WDOG_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (predicted_outputs.size() == 0) begin
          $error("result item with nothing expected: %b", out_data_i);
          mismatches++;
        end else begin
          want = predicted_outputs.pop_front();
          check_field("pin_a", want.pin_a, out_data_i.pin_a);
          check_field("pin_b", want.pin_b, out_data_i.pin_b);
          check_field("tick_due", want.tick_due, out_data_i.tick_due);
          check_field("running", want.running, out_data_i.running);
          if (want.tick_due) steps_due++;
        end
      end
      if (in_valid_i && in_ready_i) predicted_outputs.push_back(predict_drive(in_data_i));
      fail_count_o    <= mismatches;
      pending_count_o <= predicted_outputs.size();
      steps_due_o     <= steps_due;
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import epcd_pkg::*;

  localparam int RESET_CYCLES   = 11;
  localparam int DRAIN_CYCLES   = 4;     // output register plus spare slot, with margin
  localparam int RX_HOLD_CYCLES = 120;   // long enough to fill both output slots
  localparam int LONG_TICKS     = 200;   // long tick run under the largest settings
  localparam int PHASE_ITEMS    = 215;
  localparam int RANDOM_PHASES  = 6;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  in_item_t          in_data_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_data_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int fail_count;
  int pending_count;
  int steps_due;

  // stimulus bookkeeping
  int items_driven = 0;
  int settings_used = 0;
  int burst_left = 0;
  bit sender_eager = 1'b0;

  // receiver controls, set by the sender side; rx_hold_done is set by the receiver
  bit rx_eager = 1'b0;
  bit rx_hold_req = 1'b0;
  bit rx_hold_done = 1'b0;

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  energy_proportional_clock_drive uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  clock_drive_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .in_data_i      (in_data_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_data_i     (out_data_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count),
    .steps_due_o    (steps_due)
  );

  // power readings biased toward zero, full scale and small values
  function automatic logic [POWER_W-1:0] random_watts();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return POWER_W'($urandom_range(0, 255));
      default: return POWER_W'($urandom());
    endcase
  endfunction

  // present one item after a random gap, return at the edge it is taken
  task automatic offer_item(input op_e op, input logic [POWER_W-1:0] watts);
    in_item_t item;
    int       gap;
    int       pick;
    // alternate bursts with no idling against bursts with random gaps
    if (burst_left == 0) begin
      sender_eager = ($urandom_range(0, 3) == 0);
      rx_eager     = sender_eager;
      burst_left   = $urandom_range(20, 60);
    end
    burst_left--;
    gap = 0;
    if (!sender_eager) begin
      pick = $urandom_range(0, 99);
      if (pick >= 93)      gap = $urandom_range(10, 30);
      else if (pick >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.opcode      = op;
    item.power_watts = watts;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    items_driven++;
  endtask

  // sender stops until every expected result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // setup cycle, then access cycle; the write lands when pready is seen
  task automatic write_register(input reg_idx_e idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // registers change only with the block empty
  task automatic set_drive(input logic [ACC_W-1:0] rollover, input logic [WDOG_W-1:0] reload);
    drain_results();
    write_register(REG_ROLL_LIMIT, rollover);
    write_register(REG_WATCHDOG_RELOAD, APB_DW'(reload));
    settings_used++;
  endtask

  // mostly a reading followed by a run of ticks, sometimes loose noise
  task automatic drive_random_items(input int count);
    int sent;
    int run_len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) < 8) begin
        offer_item(OP_POWER, random_watts());
        sent++;
        run_len = $urandom_range(0, 40);
        repeat (run_len) begin
          offer_item(OP_TICK, random_watts());
          sent++;
        end
      end else begin
        run_len = $urandom_range(1, 4);
        repeat (run_len) begin
          offer_item(op_e'($urandom_range(0, 1)), random_watts());
          sent++;
        end
      end
    end
  endtask

  // receiver: random stalls, eager stretches, one long hold-off on request
  initial begin
    int pick;
    int len;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req && !rx_hold_done) begin
        rx_hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
      end else if (rx_eager) begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          out_ready_i <= 1'b1;
          len = $urandom_range(1, 20);
        end else if (pick < 92) begin
          out_ready_i <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          out_ready_i <= 1'b0;
          len = $urandom_range(10, 30);
        end
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // stimulus and verdict
  initial begin
    int ph;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: ticks with the watchdog stopped, then a zero and a full-scale reading
    offer_item(OP_TICK, '1);
    offer_item(OP_TICK, '0);
    offer_item(OP_POWER, '0);
    offer_item(OP_TICK, '1);
    offer_item(OP_POWER, '1);
    // full power beats the default rollover every tick: walk all sequencer phases
    repeat (12) offer_item(OP_TICK, 20'h5A5A5);

    // smallest settings: watchdog runs out after one tick, rollover of one
    set_drive(32'd1, 24'd1);
    offer_item(OP_POWER, 20'd1);
    offer_item(OP_TICK, '0);
    offer_item(OP_TICK, '1);
    offer_item(OP_POWER, 20'd2);
    offer_item(OP_TICK, '0);

    // largest settings: the accumulator climbs with no rollover
    set_drive('1, '1);
    offer_item(OP_POWER, '1);
    repeat (LONG_TICKS) offer_item(OP_TICK, random_watts());

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: set_drive(ACC_W'($urandom_range(1000, 200000)), WDOG_W'($urandom_range(1, 30)));
        1: set_drive(ACC_W'($urandom_range(1, 255)), WDOG_W'($urandom_range(1, 4096)));
        2: set_drive(ACC_W'($urandom_range(1, 32'hFFFF_FFFF)), '1);
        3: set_drive(ACC_W'($urandom_range(32'h10_0000, 32'h100_0000)),
                     WDOG_W'($urandom_range(1, 8)));
        4: set_drive(32'd1, WDOG_W'($urandom_range(16, 64)));
        default: set_drive(ACC_W'($urandom_range(1, 2000000)),
                           WDOG_W'($urandom_range(1, 24'hFF_FFFF)));
      endcase
      if (ph == 1) begin
        // receiver stalls for a long stretch while items keep coming
        rx_hold_req = 1'b1;
        drive_random_items(PHASE_ITEMS);
      end else if (ph == 3) begin
        // pause mid-phase until everything is back
        drive_random_items(PHASE_ITEMS / 2);
        drain_results();
        drive_random_items(PHASE_ITEMS - PHASE_ITEMS / 2);
      end else begin
        drive_random_items(PHASE_ITEMS);
      end
    end

    drain_results();
    $display("covered %0d items over %0d register settings, %0d clock steps due",
             items_driven, settings_used, steps_due);
    $display("included watchdog expiry, extreme settings, long output stall and full drain");
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
hdl/epcd_pkg.sv
hdl/epcd_regs.sv
hdl/epcd_step.sv
hdl/energy_proportional_clock_drive.sv
sim/clock_drive_checker.sv
sim/testbench.sv
